### hw/rtl/cpp_pkg.sv
// Shared constants and types for the camera point projection block.
// No dependencies.
`default_nettype none
package cpp_pkg;
  localparam int NUM_CAMERAS_DEF = 4;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WORDS_PER_CAM   = 20;
  localparam int MATRIX_WORDS    = 16;
  localparam int PRODUCT_WORDS   = 12;
  localparam int WORD_VW         = 16;
  localparam int WORD_VH         = 17;
  localparam int WORD_VX         = 18;
  localparam int WORD_VY         = 19;
  localparam int DEPTH_BIAS      = 5000;
  localparam int DEPTH_MAX       = 10000;
  localparam int DEGEN_SCALE     = 100;
  localparam int QUOT_W          = 42;
  localparam int QUOT_CAP_BIT    = 40;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  typedef struct packed {
    logic start;
    logic minus;
  } axis_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/camera_point_projection.sv
// Top level: camera table RAM, sequencer with multiply-accumulate, axis unit.
// Depends on cpp_pkg, cpp_ram, cpp_axis.
//
// A load beat writes one camera word. A point beat makes 20 reads of the
// camera RAM through a one-multiplier accumulate pipeline, a depth and
// degeneracy check, then two passes of the shared axis unit, each dominated
// by its bit-serial divide of (T_W+32) steps plus its multiply and finish
// states. A degenerate point skips the axis passes. The result sits in an
// output register, so loads are taken while it waits; a point that
// finishes while the previous result is still stalled holds until the
// output is free.
`default_nettype none
module camera_point_projection #(
  parameter int NUM_CAMERAS = cpp_pkg::NUM_CAMERAS_DEF,
  parameter int FRAC_BITS   = cpp_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               kind,
  input  wire logic [1:0]         camera_sel,
  input  wire logic [4:0]         word_index,
  input  wire logic signed [31:0] word_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [31:0]      view_x,
  output logic signed [31:0]      view_y,
  output logic [13:0]             screen_depth,
  output logic                    degenerate
);
  localparam int WPC    = cpp_pkg::WORDS_PER_CAM;
  localparam int DEPTH  = NUM_CAMERAS * WPC;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int T_W    = 67 - FRAC_BITS;
  localparam int D_W    = T_W + 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_AXX   = 7'b0010000,
    S_AXY   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [4:0]  cnt;
  logic [1:0]  cam;
  logic signed [31:0] px, py, pz;
  logic signed [31:0] vw, vh, vx, vy;
  logic signed [T_W-1:0] acc [4];
  logic        s1_valid, s2_valid;
  logic [4:0]  s1_idx, s2_idx;
  logic signed [63:0] prod;
  logic        degen_r;
  logic [13:0] depth_r;
  logic signed [31:0] sx_r;

  logic        accept, cam_ok, idx_ok;
  logic        we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] rdata;
  logic signed [31:0] p_mul;
  logic signed [63:0] q_term;
  logic [T_W-1:0] tw_mag;
  logic        degen_now;
  logic signed [T_W:0] dv;
  logic signed [T_W:0] dsh;
  logic [13:0] depth_now;
  cpp_pkg::axis_ctl_t ax_ctl;
  logic        ax_done;
  logic signed [31:0] ax_res;

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign cam_ok = 32'(camera_sel) < 32'(NUM_CAMERAS);
  assign idx_ok = 32'(word_index) < 32'(WPC);
  assign we     = accept && (kind == cpp_pkg::KIND_LOAD) && cam_ok && idx_ok;
  assign waddr  = ADDR_W'(32'(camera_sel) * 32'(WPC) + 32'(word_index));
  assign raddr  = ADDR_W'(32'(cam) * 32'(WPC) + 32'(cnt));

  cpp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(word_value),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    unique case (s1_idx[3:2])
      2'd0:    p_mul = px;
      2'd1:    p_mul = py;
      default: p_mul = pz;
    endcase
  end

  // products truncate toward zero after the shift
  always_comb begin
    if (32'(s2_idx) < 32'(cpp_pkg::PRODUCT_WORDS)) begin
      if (prod < 0) q_term = (prod + 64'((64'sd1 <<< FRAC_BITS) - 1)) >>> FRAC_BITS;
      else          q_term = prod >>> FRAC_BITS;
    end else begin
      q_term = prod;
    end
  end

  assign tw_mag    = acc[3][T_W-1] ? T_W'(-acc[3]) : T_W'(acc[3]);
  assign degen_now = (D_W'(tw_mag) * D_W'(cpp_pkg::DEGEN_SCALE)) < (D_W'(1) << FRAC_BITS);
  assign dv  = (T_W+1)'(acc[2]) + ((T_W+1)'(cpp_pkg::DEPTH_BIAS) <<< FRAC_BITS);
  assign dsh = dv >>> FRAC_BITS;
  always_comb begin
    if (dv < 0)                                          depth_now = '0;
    else if (dsh > (T_W+1)'(cpp_pkg::DEPTH_MAX))         depth_now = 14'(cpp_pkg::DEPTH_MAX);
    else                                                 depth_now = dsh[13:0];
  end

  always_comb begin
    ax_ctl.start = 1'b0;
    ax_ctl.minus = 1'b0;
    if (state == S_CHECK && !degen_now) ax_ctl.start = 1'b1;
    if (state == S_AXX && ax_done) begin
      ax_ctl.start = 1'b1;
      ax_ctl.minus = 1'b1;
    end
  end

  cpp_axis #(.T_W(T_W)) u_axis (
    .clk(clk), .rst(rst), .ctl(ax_ctl),
    .t((state == S_AXX) ? acc[1] : acc[0]), .tw(acc[3]),
    .size((state == S_AXX) ? vh : vw), .off((state == S_AXX) ? vy : vx),
    .done(ax_done), .result(ax_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_READ);
      s1_idx   <= cnt;
      s2_valid <= s1_valid && (32'(s1_idx) < 32'(cpp_pkg::MATRIX_WORDS));
      s2_idx   <= s1_idx;
      if (s1_valid) begin
        if (32'(s1_idx) < 32'(cpp_pkg::PRODUCT_WORDS)) prod <= $signed(rdata) * p_mul;
        else                                           prod <= 64'($signed(rdata));
        unique case (32'(s1_idx))
          cpp_pkg::WORD_VW: vw <= rdata;
          cpp_pkg::WORD_VH: vh <= rdata;
          cpp_pkg::WORD_VX: vx <= rdata;
          cpp_pkg::WORD_VY: vy <= rdata;
          default: ;
        endcase
      end
      if (s2_valid) acc[s2_idx[1:0]] <= acc[s2_idx[1:0]] + T_W'(q_term);

      unique case (state)
        S_IDLE: if (accept && kind == cpp_pkg::KIND_POINT) begin
          cam <= camera_sel;
          px  <= point_x;
          py  <= point_y;
          pz  <= point_z;
          cnt <= '0;
          for (int i = 0; i < 4; i++) acc[i] <= '0;
          if (cam_ok) begin
            state <= S_READ;
          end else begin
            degen_r <= 1'b1;
            state   <= S_OUT;
          end
        end
        S_READ: begin
          cnt <= cnt + 5'd1;
          if (32'(cnt) == WPC - 1) state <= S_DRAIN;
        end
        S_DRAIN: if (!s1_valid && !s2_valid) state <= S_CHECK;
        S_CHECK: begin
          degen_r <= degen_now;
          depth_r <= depth_now;
          state   <= degen_now ? S_OUT : S_AXX;
        end
        S_AXX: if (ax_done) begin
          sx_r  <= ax_res;
          state <= S_AXY;
        end
        // the axis unit holds its result until its next start
        S_AXY: if (ax_done) state <= S_OUT;
        S_OUT: ;
        default: state <= S_IDLE;
      endcase

      // output register takes the beat once the previous one has left
      if (state == S_OUT && (!result_valid || !result_stall)) begin
        view_x       <= degen_r ? '0 : sx_r;
        view_y       <= degen_r ? '0 : ax_res;
        screen_depth <= degen_r ? '0 : depth_r;
        degenerate   <= degen_r;
        result_valid <= 1'b1;
        state        <= S_IDLE;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/cpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/cpp_axis.sv
// Screen axis mapping: trunc(size/2 +/- t*size/(2*tw)) + off, saturated.
// Two-pass wide multiply, bit-serial restoring divide. Uses cpp_pkg.
`default_nettype none
module cpp_axis #(
  parameter int T_W = 51
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cpp_pkg::axis_ctl_t    ctl,
  input  wire logic signed [T_W-1:0] t,
  input  wire logic signed [T_W-1:0] tw,
  input  wire logic signed [31:0]    size,
  input  wire logic signed [31:0]    off,
  output logic                       done,
  output logic signed [31:0]         result
);
  localparam int N_W   = T_W + 32;
  localparam int R_W   = T_W + 2;
  localparam int Q_W   = cpp_pkg::QUOT_W;
  localparam int A_W   = Q_W + 2;
  localparam int CNT_W = $clog2(N_W + 1);

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_MLO  = 7'b0000010,
    A_MHI  = 7'b0000100,
    A_SUM  = 7'b0001000,
    A_DIV  = 7'b0010000,
    A_FIN1 = 7'b0100000,
    A_FIN2 = 7'b1000000
  } axis_state_t;

  axis_state_t state;
  logic [T_W-1:0]   t_mag;
  logic [T_W:0]     den;
  logic [31:0]      s_mag;
  logic             neg;
  logic signed [31:0] half;
  logic signed [31:0] off_r;
  logic [63:0]      p_lo;
  logic [63:0]      prod;
  logic [N_W-1:0]   num;
  logic [R_W-1:0]   rem;
  logic [Q_W-1:0]   q;
  logic             big;
  logic [CNT_W-1:0] cnt;
  logic signed [A_W-1:0] a_r;

  logic [31:0]      mul_a;
  logic [R_W-1:0]   rem_sh;
  logic [R_W:0]     diff;
  logic             ge;
  logic [Q_W-1:0]   qv;
  logic signed [A_W-1:0] a_raw;
  logic signed [A_W-1:0] a_fix;
  logic signed [A_W:0]   s_sum;
  logic [T_W-1:0]   tw_mag;

  assign mul_a  = (state == A_MLO) ? t_mag[31:0] : 32'(t_mag[T_W-1:32]);
  assign rem_sh = {rem[R_W-2:0], num[N_W-1]};
  assign diff   = {1'b0, rem_sh} - (R_W+1)'(den);
  assign ge     = !diff[R_W];
  assign qv     = big ? (Q_W'(1) << cpp_pkg::QUOT_CAP_BIT) : q;
  assign a_raw  = neg ? (A_W'(half) - A_W'(qv)) : (A_W'(half) + A_W'(qv));
  assign tw_mag = tw[T_W-1] ? T_W'(-tw) : T_W'(tw);

  always_comb begin
    a_fix = a_raw;
    if (rem != '0) begin
      if (!neg && a_raw < 0)     a_fix = a_raw + A_W'(1);
      else if (neg && a_raw > 0) a_fix = a_raw - A_W'(1);
    end
  end

  assign s_sum = (A_W+1)'(a_r) + (A_W+1)'(off_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: if (ctl.start) begin
          t_mag <= t[T_W-1] ? T_W'(-t) : T_W'(t);
          den   <= {tw_mag, 1'b0};
          s_mag <= size[31] ? 32'(-size) : 32'(size);
          neg   <= ctl.minus ^ t[T_W-1] ^ size[31] ^ tw[T_W-1];
          half  <= size / 2;
          off_r <= off;
          state <= A_MLO;
        end
        A_MLO: begin
          prod  <= mul_a * s_mag;
          state <= A_MHI;
        end
        A_MHI: begin
          p_lo  <= prod;
          prod  <= mul_a * s_mag;
          state <= A_SUM;
        end
        A_SUM: begin
          num   <= N_W'(p_lo) + (N_W'(prod) << 32);
          rem   <= '0;
          q     <= '0;
          big   <= 1'b0;
          cnt   <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          rem <= ge ? diff[R_W-1:0] : rem_sh;
          q   <= {q[Q_W-2:0], ge};
          big <= big | q[Q_W-1];
          num <= {num[N_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(N_W - 1)) state <= A_FIN1;
        end
        A_FIN1: begin
          a_r   <= a_fix;
          state <= A_FIN2;
        end
        A_FIN2: begin
          if (s_sum > (A_W+1)'(32'sh7fffffff))       result <= 32'sh7fffffff;
          else if (s_sum < -(A_W+1)'(33'sh80000000)) result <= 32'sh80000000;
          else                                      result <= s_sum[31:0];
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/cpp_checker.sv
// Port-level checks for camera_point_projection, bound to the top level.
// Depends on cpp_pkg.
`default_nettype none
module cpp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_stall,
  input wire logic               kind,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [31:0] view_x,
  input wire logic signed [31:0] view_y,
  input wire logic [13:0]        screen_depth,
  input wire logic               degenerate
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(view_x)
      && $stable(view_y) && $stable(screen_depth) && $stable(degenerate))
    else $error("result beat changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> view_x == 0 && view_y == 0 && screen_depth == 0)
    else $error("degenerate result with nonzero fields");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> screen_depth <= 14'(cpp_pkg::DEPTH_MAX))
    else $error("depth out of range");

  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == cpp_pkg::KIND_POINT |=> item_stall)
    else $error("point beat did not occupy the block");
endmodule

bind camera_point_projection cpp_checker u_cpp_checker (.*);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for camera_point_projection: fills the camera table,
// runs a directed table and random load/point beats, checks every result.
// Depends on cpp_pkg and the camera_point_projection RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS = 1100;
  localparam longint ONE_Q = 64'sd65536;

  typedef struct {
    logic              kind;
    logic [1:0]        cam;
    logic [4:0]        widx;
    logic signed [31:0] wval, px, py, pz;
    bit                typed;
    logic signed [31:0] ex, ey;
    logic [13:0]       ed;
    logic              eg;
  } beat_t;

  typedef struct {
    logic signed [31:0] sx, sy;
    logic [13:0]        depth;
    logic               degen;
  } screen_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic kind = cpp_pkg::KIND_POINT;
  logic [1:0] camera_sel = '0;
  logic [4:0] word_index = '0;
  logic signed [31:0] word_value = '0, point_x = '0, point_y = '0, point_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] view_x, view_y;
  logic [13:0] screen_depth;
  logic degenerate;

  logic signed [31:0] cam_table [cpp_pkg::NUM_CAMERAS_DEF][cpp_pkg::WORDS_PER_CAM];
  screen_t pending_screens[$];
  int errors = 0, points_sent = 0, loads_sent = 0, results_seen = 0, degen_seen = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  longint cycles = 0;

  camera_point_projection dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // fixed-point product, truncated toward zero
  function automatic longint fx_mul(longint m, longint p);
    return (m * p) / ONE_Q;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] map_axis(longint t, longint tw, longint sz,
                                                  longint off, bit minus);
    longint half, a;
    bit neg;
    logic [127:0] num, den, q, r;
    half = sz / 2;
    neg = minus ^ (t < 0) ^ (sz < 0) ^ (tw < 0);
    num = 128'(magnitude(t)) * 128'(magnitude(sz));
    den = 128'(magnitude(tw)) * 128'd2;
    q = num / den;
    r = num % den;
    if (q > (128'd1 << cpp_pkg::QUOT_CAP_BIT)) q = 128'd1 << cpp_pkg::QUOT_CAP_BIT;
    a = neg ? half - longint'(q[63:0]) : half + longint'(q[63:0]);
    if (r != 0) begin
      if (!neg && a < 0) a = a + 1;
      else if (neg && a > 0) a = a - 1;
    end
    return sat32(a + off);
  endfunction

  function automatic screen_t project_point(logic [1:0] cam, logic signed [31:0] px,
                                            logic signed [31:0] py, logic signed [31:0] pz);
    screen_t s;
    longint t [4];
    longint d;
    for (int c = 0; c < 4; c++)
      t[c] = fx_mul(longint'(cam_table[cam][c]), longint'(px))
           + fx_mul(longint'(cam_table[cam][4+c]), longint'(py))
           + fx_mul(longint'(cam_table[cam][8+c]), longint'(pz))
           + longint'(cam_table[cam][12+c]);
    s = '{sx: 0, sy: 0, depth: 0, degen: 1'b1};
    if (magnitude(t[3]) * 64'(cpp_pkg::DEGEN_SCALE) < 64'(ONE_Q)) return s;
    d = (t[2] + longint'(cpp_pkg::DEPTH_BIAS) * ONE_Q) / ONE_Q;
    if (d < 0) d = 0;
    if (d > longint'(cpp_pkg::DEPTH_MAX)) d = longint'(cpp_pkg::DEPTH_MAX);
    s.depth = d[13:0];
    s.degen = 1'b0;
    s.sx = map_axis(t[0], t[3], longint'(cam_table[cam][cpp_pkg::WORD_VW]),
                    longint'(cam_table[cam][cpp_pkg::WORD_VX]), 1'b0);
    s.sy = map_axis(t[1], t[3], longint'(cam_table[cam][cpp_pkg::WORD_VH]),
                    longint'(cam_table[cam][cpp_pkg::WORD_VY]), 1'b1);
    return s;
  endfunction

  function automatic beat_t load_beat(logic [1:0] cam, logic [4:0] widx, logic signed [31:0] v);
    beat_t b;
    b = '{kind: cpp_pkg::KIND_LOAD, cam: cam, widx: widx, wval: v, default: '0};
    return b;
  endfunction

  function automatic beat_t point_beat(logic [1:0] cam, logic signed [31:0] px,
                                       logic signed [31:0] py, logic signed [31:0] pz);
    beat_t b;
    b = '{kind: cpp_pkg::KIND_POINT, cam: cam, px: px, py: py, pz: pz, default: '0};
    return b;
  endfunction

  function automatic beat_t typed_point(logic [1:0] cam, logic signed [31:0] px,
                                        logic signed [31:0] py, logic signed [31:0] pz,
                                        logic signed [31:0] ex, logic signed [31:0] ey,
                                        logic [13:0] ed, logic eg);
    beat_t b;
    b = point_beat(cam, px, py, pz);
    b.typed = 1'b1;
    b.ex = ex; b.ey = ey; b.ed = ed; b.eg = eg;
    return b;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom();
    return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
  endfunction

  task automatic send(beat_t b);
    screen_t s;
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= b.kind;
    camera_sel <= b.cam;
    word_index <= b.widx;
    word_value <= b.wval;
    point_x <= b.px;
    point_y <= b.py;
    point_z <= b.pz;
    do @(posedge clk); while (item_stall);
    if (b.kind == cpp_pkg::KIND_LOAD) begin
      loads_sent++;
      if (b.widx < cpp_pkg::WORDS_PER_CAM) cam_table[b.cam][b.widx] = b.wval;
    end else begin
      points_sent++;
      s = project_point(b.cam, b.px, b.py, b.pz);
      if (b.typed) s = '{sx: b.ex, sy: b.ey, depth: b.ed, degen: b.eg};
      pending_screens.push_back(s);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) result_stall <= ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    screen_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (degenerate) degen_seen++;
      if (pending_screens.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_screens.pop_front();
        if (view_x !== e.sx) begin
          $error("view_x exp %0d got %0d", e.sx, view_x); errors++;
        end
        if (view_y !== e.sy) begin
          $error("view_y exp %0d got %0d", e.sy, view_y); errors++;
        end
        if (screen_depth !== e.depth) begin
          $error("screen_depth exp %0d got %0d", e.depth, screen_depth); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_screens.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    beat_t directed [$];
    beat_t b;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table word is written before any point reads it
    // cam 0: identity, tw = 1.0, 640x480 viewport at the origin; cam 1: all zero
    for (int c = 0; c < cpp_pkg::NUM_CAMERAS_DEF; c++)
      for (int w = 0; w < cpp_pkg::WORDS_PER_CAM; w++) begin
        if (c == 0)
          b = load_beat(2'(c), 5'(w), (w < cpp_pkg::MATRIX_WORDS) ?
                              ((w % 5 == 0) ? 32'sh10000 : 0) :
                              (w == cpp_pkg::WORD_VW) ? 640 :
                              (w == cpp_pkg::WORD_VH) ? 480 : 0);
        else if (c == 1)
          b = load_beat(2'(c), 5'(w), 32'sd0);
        else
          b = load_beat(2'(c), 5'(w), (w < cpp_pkg::MATRIX_WORDS) ?
                              rand_coord() : $urandom_range(1, 2000));
        send(b);
      end

    directed.push_back(typed_point(2'd0, 0, 0, 0, 320, 240, 14'd5000, 1'b0));
    directed.push_back(typed_point(2'd1, 32'sh12345678, -5, 9, 0, 0, 14'd0, 1'b1));
    directed.push_back(typed_point(2'd1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                   0, 0, 14'd0, 1'b1));
    directed.push_back(load_beat(2'd1, 5'd25, 32'sh7fffffff)); // index past the table: ignored
    directed.push_back(typed_point(2'd1, 32'sh10000, 32'sh10000, 32'sh10000,
                                   0, 0, 14'd0, 1'b1));
    directed.push_back(typed_point(2'd0, 32'sh10000, 0, 0, 640, 240, 14'd5000, 1'b0));
    directed.push_back(typed_point(2'd0, 0, 0, -32'sd6000 * 65536, 320, 240, 14'd0, 1'b0));
    directed.push_back(typed_point(2'd0, 0, 0, 32'sd6000 * 65536, 320, 240, 14'd10000, 1'b0));
    directed.push_back(point_beat(2'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    directed.push_back(point_beat(2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    directed.push_back(load_beat(2'd0, 5'd15, 32'sh100));
    directed.push_back(typed_point(2'd0, 0, 0, 0, 0, 0, 14'd0, 1'b1));
    directed.push_back(load_beat(2'd0, 5'd15, 32'sd656)); // just above the w threshold
    directed.push_back(point_beat(2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh10000));
    directed.push_back(load_beat(2'd0, 5'd15, 32'sd655)); // just below it
    directed.push_back(typed_point(2'd0, 0, 0, 0, 0, 0, 14'd0, 1'b1));
    directed.push_back(load_beat(2'd0, 5'd15, 32'sh10000));
    directed.push_back(load_beat(2'd0, 5'(cpp_pkg::WORD_VW), 32'sh7fffffff));
    directed.push_back(point_beat(2'd0, 32'sh7fffffff, 32'sh7fffffff, 0));
    directed.push_back(load_beat(2'd0, 5'(cpp_pkg::WORD_VW), -32'sd640));
    directed.push_back(point_beat(2'd0, 32'sh00030000, -32'sh00028000, 0));
    directed.push_back(load_beat(2'd0, 5'(cpp_pkg::WORD_VX), 32'sh7fffffff));
    directed.push_back(point_beat(2'd0, 32'sh00030000, 32'sh80000000, 0));
    directed.push_back(load_beat(2'd2, 5'd31, 32'sh5a5a5a5a));
    foreach (directed[i]) send(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0 || n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
        drain();
        tx_idle_pct = (n == 0) ? 21 : (n == RANDOM_ITEMS / 3) ? 56 : 0;
        rx_idle_pct = (n == 0) ? 56 : (n == RANDOM_ITEMS / 3) ? 21 : 0;
      end
      r = $urandom_range(99);
      if (r < 70) begin
        b = point_beat(2'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord());
      end else begin
        b = load_beat(2'($urandom_range(3)),
                      (r < 97) ? 5'($urandom_range(19)) : 5'($urandom_range(20, 31)),
                      32'sd0);
        if ($urandom_range(99) < 20) b.wval = $urandom();
        else if (b.widx >= cpp_pkg::WORD_VW) b.wval = $urandom_range(0, 4000) - 1000;
        else b.wval = rand_coord();
      end
      send(b);
    end

    drain();
    repeat (400) @(posedge clk);
    $display("covered %0d point beats and %0d load beats, %0d results (%0d degenerate)",
             points_sent, loads_sent, results_seen, degen_seen);
    $display("three idle mixes on both channels, with full drains between them");
    if (errors == 0 && pending_screens.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
